// ===== sv/cda_pkg.sv =====
`timescale 1ns / 1ps

package cda_pkg;

    localparam int KIND_W   = 3;
    localparam int AMOUNT_W = 16;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;

    localparam logic [KIND_W-1:0] KIND_LOAD       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_DAYS   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB_DAYS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADD_MONTHS = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SUB_MONTHS = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ADD_YEARS  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SUB_YEARS  = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [AMOUNT_W-1:0] amount;
        logic [YEAR_W-1:0]   load_year;
        logic [MONTH_W-1:0]  load_month;
        logic [DAY_W-1:0]    load_day;
    } t_in;

    typedef struct packed {
        logic [YEAR_W-1:0]  date_year;
        logic [MONTH_W-1:0] date_month;
        logic [DAY_W-1:0]   date_day;
        logic               range_error;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_step;
        logic shift;
        logic walk_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic walk_fail;
    } t_sts;

endpackage

// ===== sv/calendar_date_adder_core.sv =====
`timescale 1ns / 1ps

// Gregorian date keeper: each input transaction loads a date or moves it by a count of days,
// months or years, and returns exactly one result transaction with the date after the step
// and a range_error flag (invalid load, or a year that would leave 1..MAX_YEAR; the date is
// then left as it was). Items are taken one at a time: input stall is low only while no item
// is in work and no result waits. After acceptance a load passes the wait and finish states
// before result valid rises; a year shift first passes the shift state, and a month shift
// passes a divide state before that, which splits the count into quotient and remainder
// by 12. A day shift walks in the datapath, one month per cycle, then passes the finish
// state. The next item is accepted once the controller is back in idle after the result is taken.

module calendar_date_adder_core #(
    parameter int MAX_YEAR    = 9999,
    parameter int AMOUNT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  cda_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output cda_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    cda_pkg::t_cmd cmd;
    cda_pkg::t_sts sts;

    cda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in_data.kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cda_datapath #(
        .MAX_YEAR    (MAX_YEAR),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_out     (o_out_data)
    );

endmodule

// ===== sv/cda_ctrl.sv =====
`timescale 1ns / 1ps

module cda_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [cda_pkg::KIND_W-1:0]    i_kind,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  cda_pkg::t_sts                 i_sts,
    output cda_pkg::t_cmd                 o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_kind)
                        cda_pkg::KIND_LOAD:       n_state = S_WAIT;
                        cda_pkg::KIND_ADD_DAYS:   n_state = S_WALK;
                        cda_pkg::KIND_SUB_DAYS:   n_state = S_WALK;
                        cda_pkg::KIND_ADD_MONTHS: n_state = S_DIV;
                        cda_pkg::KIND_SUB_MONTHS: n_state = S_DIV;
                        cda_pkg::KIND_ADD_YEARS:  n_state = S_SHIFT;
                        cda_pkg::KIND_SUB_YEARS:  n_state = S_SHIFT;
                        default:                  n_state = S_FIN;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state = S_WAIT;
            end
            // lets the leap-year pipe catch up with a new year
            S_WAIT: begin
                n_state = S_FIN;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_done || i_sts.walk_fail) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

`ifndef SYNTH
    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input open while a result is pending");

    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(o_cmd.finish))
        else $error("result shown without a finish step");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.div_step, o_cmd.shift, o_cmd.walk_step,
                  o_cmd.finish}))
        else $error("more than one datapath command");
`endif

endmodule

// ===== sv/cda_datapath.sv =====
`timescale 1ns / 1ps

module cda_datapath #(
    parameter int MAX_YEAR    = 9999,
    parameter int AMOUNT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cda_pkg::t_in  i_in_data,
    input  cda_pkg::t_cmd i_cmd,
    output cda_pkg::t_sts o_sts,
    output cda_pkg::t_out o_out
);

    localparam int AW = (AMOUNT_BITS < cda_pkg::AMOUNT_W) ? AMOUNT_BITS : cda_pkg::AMOUNT_W;
    localparam int NW = (AW > 5) ? AW + 1 : 6;
    localparam int SW = ((AW > cda_pkg::YEAR_W) ? AW : cda_pkg::YEAR_W) + 2;
    localparam logic [13:0] MAX_Y       = 14'(MAX_YEAR);
    localparam logic [28:0] RECIP_25    = 29'd20972;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [16:0] RECIP_3      = 17'd43691;
    localparam int          RECIP3_SHIFT = 17;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // committed date and working copy
    logic [13:0]   r_y, n_y, w_y, n_wy;
    logic [3:0]    r_m, n_m, w_m, n_wm;
    logic [4:0]    r_d, n_d, w_d, n_wd;
    logic [AW-1:0] r_n, n_n;
    logic [3:0]    r_rem, n_rem;
    logic          r_bad, n_bad;
    logic          r_back, n_back;
    logic          r_load, n_load;
    logic          r_err, n_err;
    logic [9:0]    r_q25;

    logic [28:0]   q_prod;
    logic [13:0]   q25x;
    logic          leap;
    logic [4:0]    len, len_prev, clamp_d, step_f;
    logic [NW-1:0] sum_f, rem_f, rem_b, dif_b;
    logic          fwd_fit, back_fit;
    logic [4:0]    msum, m_fwd, m_back;
    logic          carry, borrow, adj;
    logic [SW-1:0] qx, y_fwd, y_back;
    logic          shift_ok, load_bad;
    logic [15:0]   amt16;
    logic [29:0]   d_prod;
    logic [12:0]   q12;
    logic [15:0]   r12;

    // leap year from y mod 4, 16 and 25; floor(y/25) via reciprocal, registered from w_y
    assign q_prod   = 29'(w_y) * RECIP_25;
    assign q25x     = 14'(r_q25) * 14'd25;
    assign leap     = (w_y[1:0] == 2'b00) && ((w_y != q25x) || (w_y[3:0] == 4'b0000));
    assign len      = month_len(w_m, leap);
    assign len_prev = month_len(w_m - 4'd1, leap);
    assign clamp_d  = (w_d > len) ? len : w_d;

    // day walk
    assign sum_f    = NW'(w_d) + NW'(r_n);
    assign step_f   = len - w_d + 5'd1;
    assign rem_f    = NW'(r_n) - NW'(step_f);
    assign rem_b    = NW'(r_n) - NW'(w_d);
    assign dif_b    = NW'(w_d) - NW'(r_n);
    assign fwd_fit  = sum_f <= NW'(len);
    assign back_fit = NW'(w_d) > NW'(r_n);

    // month / year shift with quotient and remainder of the count by 12
    assign msum     = {1'b0, w_m} + {1'b0, r_rem};
    assign carry    = msum > 5'd12;
    assign borrow   = w_m <= r_rem;
    assign m_fwd    = carry ? msum - 5'd12 : msum;
    assign m_back   = borrow ? {1'b0, w_m} + 5'd12 - {1'b0, r_rem}
                             : {1'b0, w_m} - {1'b0, r_rem};
    assign adj      = r_back ? borrow : carry;
    assign qx       = SW'(r_n) + SW'(adj);
    assign y_fwd    = SW'(w_y) + qx;
    assign y_back   = SW'(w_y) - qx;
    assign shift_ok = r_back ? (SW'(w_y) > qx) : (y_fwd <= SW'(MAX_Y));

    // n / 12 as (n / 4) / 3, the divide by 3 via reciprocal
    assign amt16    = 16'(r_n);
    assign d_prod   = 30'(amt16[15:2]) * 30'(RECIP_3);
    assign q12      = d_prod[RECIP3_SHIFT+12:RECIP3_SHIFT];
    assign r12      = amt16 - 16'(q12) * 16'd12;

    assign load_bad = (i_in_data.load_year == 14'd0) || (i_in_data.load_year > MAX_Y)
                   || (i_in_data.load_month == 4'd0) || (i_in_data.load_month > 4'd12)
                   || (i_in_data.load_day == 5'd0);

    always_comb begin
        o_sts.walk_done = r_back ? back_fit : fwd_fit;
        o_sts.walk_fail = !o_sts.walk_done &&
                          (r_back ? ((w_m == 4'd1) && (w_y <= 14'd1))
                                  : ((w_m == 4'd12) && (w_y >= MAX_Y)));
    end

    always_comb begin
        n_y    = r_y;
        n_m    = r_m;
        n_d    = r_d;
        n_wy   = w_y;
        n_wm   = w_m;
        n_wd   = w_d;
        n_n    = r_n;
        n_rem  = r_rem;
        n_bad  = r_bad;
        n_back = r_back;
        n_load = r_load;
        n_err  = r_err;

        if (i_cmd.capture) begin
            n_n    = i_in_data.amount[AW-1:0];
            n_rem  = 4'd0;
            n_back = (i_in_data.kind == cda_pkg::KIND_SUB_DAYS)
                  || (i_in_data.kind == cda_pkg::KIND_SUB_MONTHS)
                  || (i_in_data.kind == cda_pkg::KIND_SUB_YEARS);
            n_load = (i_in_data.kind == cda_pkg::KIND_LOAD);
            n_bad  = 1'b0;
            if (i_in_data.kind == cda_pkg::KIND_LOAD) begin
                n_wy  = i_in_data.load_year;
                n_wm  = i_in_data.load_month;
                n_wd  = i_in_data.load_day;
                n_bad = load_bad;
            end
        end

        // quotient and remainder of the month count by 12
        if (i_cmd.div_step) begin
            n_n   = AW'(q12);
            n_rem = r12[3:0];
        end

        if (i_cmd.shift) begin
            if (shift_ok) begin
                n_wy = r_back ? y_back[13:0] : y_fwd[13:0];
                n_wm = r_back ? m_back[3:0] : m_fwd[3:0];
            end else begin
                n_bad = 1'b1;
            end
        end

        // one month crossed per step
        if (i_cmd.walk_step) begin
            if (o_sts.walk_fail) begin
                n_bad = 1'b1;
            end else if (o_sts.walk_done) begin
                n_wd = r_back ? dif_b[4:0] : sum_f[4:0];
            end else if (!r_back) begin
                n_n  = rem_f[AW-1:0];
                n_wd = 5'd1;
                if (w_m == 4'd12) begin
                    n_wm = 4'd1;
                    n_wy = w_y + 14'd1;
                end else begin
                    n_wm = w_m + 4'd1;
                end
            end else begin
                n_n = rem_b[AW-1:0];
                if (w_m == 4'd1) begin
                    n_wm = 4'd12;
                    n_wy = w_y - 14'd1;
                    n_wd = 5'd31;
                end else begin
                    n_wm = w_m - 4'd1;
                    n_wd = len_prev;
                end
            end
        end

        if (i_cmd.finish) begin
            if (r_bad || (r_load && (w_d > len))) begin
                n_err = 1'b1;
                n_wy  = r_y;
                n_wm  = r_m;
                n_wd  = r_d;
            end else begin
                n_err = 1'b0;
                n_y   = w_y;
                n_m   = w_m;
                n_d   = clamp_d;
                n_wd  = clamp_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y    <= 14'd2000;
            r_m    <= 4'd1;
            r_d    <= 5'd1;
            w_y    <= 14'd2000;
            w_m    <= 4'd1;
            w_d    <= 5'd1;
            r_bad  <= 1'b0;
            r_back <= 1'b0;
            r_load <= 1'b0;
            r_err  <= 1'b0;
        end else begin
            r_y    <= n_y;
            r_m    <= n_m;
            r_d    <= n_d;
            w_y    <= n_wy;
            w_m    <= n_wm;
            w_d    <= n_wd;
            r_bad  <= n_bad;
            r_back <= n_back;
            r_load <= n_load;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_rem <= n_rem;
        r_q25 <= q_prod[RECIP_SHIFT+9:RECIP_SHIFT];
    end

    always_comb begin
        o_out.date_year   = r_y;
        o_out.date_month  = r_m;
        o_out.date_day    = r_d;
        o_out.range_error = r_err;
    end

`ifndef SYNTH
    a_refused_keeps_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_bad) |=> (o_out.range_error && (o_out.date_year == $past(r_y))
            && (o_out.date_month == $past(r_m)) && (o_out.date_day == $past(r_d))))
        else $error("refused transaction changed the stored date");
`endif

endmodule
